/* hw/rtl/mrwd_pkg.sv */
// Package for minimum rate within deadline: constants and state type.
package mrwd_pkg;
    localparam int MAX_PILES_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 30;
    localparam int DL_BITS        = 30;
    localparam int SUM_BITS       = 41;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MID,
        ST_RD,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } t_state;
endpackage

/* hw/rtl/minimum_rate_within_deadline.sv */
// Top level: pile store, binary search over rates, serial divider.
//
//  channel | handshake      | payload
//  input   | start/busy     | i_pile_size, i_is_last
//  config  | i_cfg_valid/o_cfg_ready | i_cfg_data
//  result  | o_strobe       | o_min_rate, o_overflowed, o_valid_result
//
// Piles load one per cycle into the memory while busy is low.
// After the last pile, each search probe reads every stored pile and divides
// it by the rate bit-serially, over up to VALUE_BITS probes; the early stop
// shortens probes.
// Reset is synchronous active low; the store needs no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall.
module minimum_rate_within_deadline #(
    parameter int MAX_PILES  = mrwd_pkg::MAX_PILES_DEF,
    parameter int VALUE_BITS = mrwd_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [VALUE_BITS-1:0]       i_pile_size,
    input  logic                        i_is_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mrwd_pkg::DL_BITS-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic [VALUE_BITS-1:0]       o_min_rate,
    output logic                        o_overflowed,
    output logic                        o_valid_result
);
    localparam int AW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
    localparam int CW = $clog2(MAX_PILES + 1);
    localparam int VB = VALUE_BITS;
    localparam int SB = mrwd_pkg::SUM_BITS;
    localparam int DB = mrwd_pkg::DL_BITS;
    localparam int NB = $clog2(VB + 1);

    mrwd_pkg::t_state r_state, n_state;

    logic [VB-1:0] r_mem [MAX_PILES];
    logic [VB-1:0] r_rdata;
    logic [DB-1:0] r_deadline;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [VB-1:0] r_largest;
    logic          r_ovf;
    logic [VB:0]   r_low, r_high;
    logic [VB-1:0] r_mid, r_best;
    logic [SB-1:0] r_sum;
    logic [VB-1:0] r_quo, r_rem, r_dvd;
    logic [NB-1:0] r_bit;

    logic          accept;
    logic          mem_we;
    logic [VB:0]   rem_sh;
    logic [VB:0]   rem_sub;
    logic [SB-1:0] sum_add;
    logic [VB:0]   mid_w;

    assign accept      = start && !busy;
    assign busy        = (r_state != mrwd_pkg::ST_LOAD);
    assign o_cfg_ready = !busy;
    assign mem_we      = accept && (r_count < CW'(MAX_PILES));
    assign rem_sh      = {r_rem, r_dvd[VB-1]};
    assign rem_sub     = rem_sh - {1'b0, r_mid};
    assign sum_add     = r_sum + SB'(r_quo) + SB'(r_rem != '0);
    assign mid_w       = r_low + ((r_high - r_low) >> 1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= i_pile_size;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrwd_pkg::ST_LOAD: if (accept && i_is_last) n_state = mrwd_pkg::ST_MID;
            mrwd_pkg::ST_MID: begin
                if (r_low > r_high) n_state = mrwd_pkg::ST_DONE;
                else if (r_count == '0) n_state = mrwd_pkg::ST_MID;
                else n_state = mrwd_pkg::ST_RD;
            end
            mrwd_pkg::ST_RD:  n_state = mrwd_pkg::ST_DIV;
            mrwd_pkg::ST_DIV: if (r_bit == NB'(1)) n_state = mrwd_pkg::ST_ACC;
            mrwd_pkg::ST_ACC: begin
                if (sum_add > SB'(r_deadline) || r_idx + 1'b1 == r_count)
                    n_state = mrwd_pkg::ST_MID;
                else
                    n_state = mrwd_pkg::ST_RD;
            end
            mrwd_pkg::ST_DONE: n_state = mrwd_pkg::ST_LOAD;
            default: n_state = mrwd_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mrwd_pkg::ST_LOAD;
            r_deadline <= DB'(1);
            r_count    <= '0;
            r_largest  <= '0;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_low      <= '0;
            r_high     <= '0;
            o_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == mrwd_pkg::ST_DONE);
            if (i_cfg_valid && o_cfg_ready) r_deadline <= i_cfg_data;
            unique case (r_state)
                mrwd_pkg::ST_LOAD: if (accept) begin
                    if (mem_we) begin
                        r_count <= r_count + 1'b1;
                        if (i_pile_size > r_largest) r_largest <= i_pile_size;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_low  <= (VB+1)'(1);
                    r_high <= {1'b0, (mem_we && i_pile_size > r_largest) ?
                                     i_pile_size : r_largest};
                    r_best <= VB'(r_deadline);
                    r_idx  <= '0;
                end
                mrwd_pkg::ST_MID: if (r_low <= r_high) begin
                    if (r_count == '0) begin
                        r_best <= mid_w[VB-1:0];
                        r_high <= mid_w - 1'b1;
                    end
                    r_mid  <= mid_w[VB-1:0];
                    r_idx  <= '0;
                    r_sum  <= '0;
                end
                mrwd_pkg::ST_RD: begin
                    r_bit <= NB'(VB);
                    r_rem <= '0;
                    r_quo <= '0;
                end
                mrwd_pkg::ST_DIV: begin
                    if (r_bit == NB'(VB)) begin
                        // first cycle: operand now valid from memory
                        r_dvd <= r_rdata << 1;
                        if ({{VB{1'b0}}, r_rdata[VB-1]} >= {1'b0, r_mid}) begin
                            r_rem <= VB'({{VB{1'b0}}, r_rdata[VB-1]} - {1'b0, r_mid});
                            r_quo <= VB'(1);
                        end else begin
                            r_rem <= VB'(r_rdata[VB-1]);
                            r_quo <= '0;
                        end
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (!rem_sub[VB]) begin
                            r_rem <= rem_sub[VB-1:0];
                            r_quo <= {r_quo[VB-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[VB-1:0];
                            r_quo <= {r_quo[VB-2:0], 1'b0};
                        end
                    end
                    r_bit <= r_bit - 1'b1;
                end
                mrwd_pkg::ST_ACC: begin
                    r_sum <= sum_add;
                    r_idx <= r_idx + 1'b1;
                    if (sum_add > SB'(r_deadline)) begin
                        r_low <= {1'b0, r_mid} + 1'b1;
                    end else if (r_idx + 1'b1 == r_count) begin
                        r_best <= r_mid;
                        r_high <= {1'b0, r_mid} - 1'b1;
                    end
                end
                mrwd_pkg::ST_DONE: begin
                    o_min_rate     <= r_best;
                    o_overflowed   <= r_ovf;
                    o_valid_result <= 1'b1;
                    r_count        <= '0;
                    r_largest      <= '0;
                    r_ovf          <= 1'b0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("config ready while busy");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PILES)) else $error("pile count beyond capacity");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_count == '0 && !r_ovf)) else $error("set not cleared");
`endif
endmodule

/* tb/tb.sv */
// Testbench for minimum_rate_within_deadline: randomized pile sets checked against a predictor.
`timescale 1ns / 100ps

module tb;
    localparam int NPILES = mrwd_pkg::MAX_PILES_DEF;
    localparam int VBITS  = mrwd_pkg::VALUE_BITS_DEF;
    localparam int DBITS  = mrwd_pkg::DL_BITS;
    localparam logic [VBITS-1:0] PILE_MAX = {VBITS{1'b1}};
    localparam logic [DBITS-1:0] DL_MAX = {DBITS{1'b1}};
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [VBITS-1:0] pile;
        logic             last;
        logic             drain;
    } t_pile_txn;

    typedef struct {
        logic [VBITS-1:0] rate;
        logic             ovf;
    } t_rate_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [VBITS-1:0]     i_pile_size;
    logic                 i_is_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [DBITS-1:0]     i_cfg_data;
    logic                 o_strobe;
    logic [VBITS-1:0]     o_min_rate;
    logic                 o_overflowed;
    logic                 o_valid_result;

    minimum_rate_within_deadline dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pile_size    (i_pile_size),
        .i_is_last      (i_is_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_min_rate     (o_min_rate),
        .o_overflowed   (o_overflowed),
        .o_valid_result (o_valid_result)
    );

    t_pile_txn    pending_piles[$];
    t_rate_result expected_rates[$];

    logic [VBITS-1:0] pile_mem [NPILES];
    int               stored_cnt;
    logic [VBITS-1:0] peak_pile;
    logic             ovf_flag;
    logic [DBITS-1:0] deadline;

    int  mismatches;
    int  results_seen;
    int  sets_sent;
    int  ovf_sets;
    int  idle_cycles;
    bit  pile_fired;
    int  burst_left;
    int  gap_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit rate_ok(logic [VBITS-1:0] rate);
        longint unsigned hours;
        hours = 0;
        for (int i = 0; i < stored_cnt; i++) begin
            hours += (longint'(pile_mem[i]) + rate - 1) / rate;
            if (hours > deadline) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_rate_result search_min_rate();
        t_rate_result r;
        longint unsigned lo, hi, mid;
        lo = 1;
        hi = peak_pile;
        r.rate = deadline;
        r.ovf = ovf_flag;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (rate_ok(mid[VBITS-1:0])) begin
                r.rate = mid[VBITS-1:0];
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    // Monitor and predictor
    always @(posedge i_clk) begin
        t_rate_result exp_r;
        pile_fired = 1'b0;
        if (!i_rst_n) begin
            stored_cnt = 0;
            peak_pile  = '0;
            ovf_flag   = 1'b0;
            deadline   = DBITS'(1);
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (o_strobe) begin
                idle_cycles = 0;
                results_seen++;
                if (expected_rates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: unexpected result rate=%0d ovf=%0b", o_min_rate,
                                 o_overflowed);
                end else begin
                    exp_r = expected_rates.pop_front();
                    if (o_min_rate !== exp_r.rate || o_overflowed !== exp_r.ovf ||
                        o_valid_result !== 1'b1) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("ERROR: exp rate=%0d ovf=%0b, got rate=%0d ovf=%0b vld=%0b",
                                     exp_r.rate, exp_r.ovf, o_min_rate, o_overflowed,
                                     o_valid_result);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                idle_cycles = 0;
                deadline = i_cfg_data;
            end
            if (start && !busy) begin
                idle_cycles = 0;
                pile_fired = 1'b1;
                if (stored_cnt < NPILES) begin
                    pile_mem[stored_cnt] = i_pile_size;
                    stored_cnt++;
                    if (i_pile_size > peak_pile) peak_pile = i_pile_size;
                end else begin
                    ovf_flag = 1'b1;
                end
                if (i_is_last) begin
                    expected_rates.push_back(search_min_rate());
                    stored_cnt = 0;
                    peak_pile  = '0;
                    ovf_flag   = 1'b0;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Driver: bursts with random gaps; drain items wait for all results
    always @(negedge i_clk) begin
        t_pile_txn t;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_pile_size <= '0;
            i_is_last   <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (start && !pile_fired) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (pending_piles.size() != 0 &&
                     !(pending_piles[0].drain && (expected_rates.size() != 0 || busy))) begin
            t = pending_piles.pop_front();
            start       <= 1'b1;
            i_pile_size <= t.pile;
            i_is_last   <= t.last;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            start <= 1'b0;
        end
    end

    task automatic add_pile(input logic [VBITS-1:0] p, input logic last,
                            input logic drain = 1'b0);
        t_pile_txn t;
        t.pile = p;
        t.last = last;
        t.drain = drain;
        pending_piles.push_back(t);
        if (last) sets_sent++;
    endtask

    task automatic wait_idle();
        wait (pending_piles.size() == 0 && !start && expected_rates.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_deadline(input logic [DBITS-1:0] d);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_sets(input int n_items);
        int sent, sz, w;
        logic [VBITS-1:0] p;
        sent = 0;
        while (sent < n_items) begin
            sz = $urandom_range(1, 6);
            for (int i = 0; i < sz; i++) begin
                w = $urandom_range(1, VBITS);
                p = VBITS'($urandom() & ((32'd1 << w) - 1));
                add_pile(p, i == sz - 1, i == 0 && $urandom_range(0, 19) == 0);
            end
            sent += sz;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        mismatches  = 0;
        results_seen = 0;
        sets_sent   = 0;
        ovf_sets    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset deadline of one
        add_pile(PILE_MAX, 1'b1);
        add_pile('0, 1'b1);
        add_pile(VBITS'(5), 1'b0);
        add_pile(VBITS'(7), 1'b1);
        write_deadline('0);
        add_pile(VBITS'(3), 1'b1);
        add_pile('0, 1'b0);
        add_pile('0, 1'b1);
        write_deadline(DL_MAX);
        add_pile(PILE_MAX, 1'b0);
        add_pile(PILE_MAX, 1'b0);
        add_pile(VBITS'(1), 1'b1);
        add_pile(30'h2AAAAAAA, 1'b0);
        add_pile(30'h15555555, 1'b1);
        write_deadline(DBITS'(10));
        // store overflow: small piles keep the search short
        for (int i = 0; i < NPILES + 6; i++)
            add_pile(VBITS'($urandom_range(0, 3)), i == NPILES + 5);
        ovf_sets++;
        add_pile(VBITS'(9), 1'b0, 1'b1);
        add_pile(VBITS'(4), 1'b1);

        write_deadline(DBITS'($urandom_range(1, 20)));
        random_sets(115);
        write_deadline(DBITS'($urandom()));
        random_sets(115);
        write_deadline(DBITS'(1));
        random_sets(115);
        write_deadline(DL_MAX);
        random_sets(115);

        wait_idle();
        $display("Covered %0d pile sets (%0d with store overflow), %0d results checked,",
                 sets_sent, ovf_sets, results_seen);
        $display("deadlines from zero to full range, %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
